FILE: hw/rtl/mbd_pkg.sv
// Shared types, field widths and constants of the multi-button debouncer.
package mbd_pkg;

   // Field widths of the channels and the register port
   localparam int ActionW = 2;
   localparam int IdxW    = 2;
   localparam int PinW    = 4;
   localparam int DelayW  = 7;
   localparam int StatusW = 5;
   localparam int CsrIdxW = 1;
   localparam int CodeW   = 2;

   // Register reset values
   localparam logic [DelayW-1:0] PressDelayRst   = 7'd20;
   localparam logic [DelayW-1:0] ReleaseDelayRst = 7'd100;

   // Request opcodes; the fourth code does nothing
   typedef enum logic [ActionW-1:0] {
      ACT_TICK = 2'd0,
      ACT_EDGE = 2'd1,
      ACT_READ = 2'd2
   } action_type;

   // Register indexes
   typedef enum logic [CsrIdxW-1:0] {
      CSR_PRESS_DELAY   = 1'b0,
      CSR_RELEASE_DELAY = 1'b1
   } csr_index_type;

   // Per-button debounce state
   typedef enum logic [2:0] {
      BTN_UP     = 3'b001,
      BTN_DOWN   = 3'b010,
      BTN_UNSURE = 3'b100
   } btn_state_type;

   // Status codes as reported in the status word
   localparam logic [CodeW-1:0] CodeUp     = 2'd0;
   localparam logic [CodeW-1:0] CodeDown   = 2'd1;
   localparam logic [CodeW-1:0] CodeUnsure = 2'd2;

   // Command from the decode stage to one button
   typedef struct packed {
      logic tick;
      logic edge_hit;
      logic pin;
   } btn_cmd_type;

   function automatic logic [CodeW-1:0] state_code(btn_state_type st);
      logic [CodeW-1:0] code;
      unique case (st)
         BTN_UP:     code = CodeUp;
         BTN_DOWN:   code = CodeDown;
         BTN_UNSURE: code = CodeUnsure;
         default:    code = CodeUp;
      endcase
      return code;
   endfunction

endpackage

FILE: hw/rtl/mbd_req_if.sv
// Request channel: valid/ready handshake with action, button index and pin levels.
interface mbd_req_if;
   import mbd_pkg::*;

   logic               valid;
   logic               ready;
   logic [ActionW-1:0] action;
   logic [IdxW-1:0]    button_index;
   logic [PinW-1:0]    pin_levels;

   modport source (output valid, action, button_index, pin_levels, input ready);
   modport sink   (input valid, action, button_index, pin_levels, output ready);
endinterface

FILE: hw/rtl/mbd_rsp_if.sv
// Response channel: valid/ready handshake with status word and event flags.
interface mbd_rsp_if;
   import mbd_pkg::*;

   logic               valid;
   logic               ready;
   logic [StatusW-1:0] status_word;
   logic               read_ok;
   logic               event_pending;

   modport source (output valid, status_word, read_ok, event_pending, input ready);
   modport sink   (input valid, status_word, read_ok, event_pending, output ready);
endinterface

FILE: hw/rtl/mbd_button.sv
// One button: debounce state, countdown timer and armed flag.
module mbd_button (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  mbd_pkg::btn_cmd_type          cmd,
   input  logic [mbd_pkg::DelayW-1:0]    press_delay,
   input  logic [mbd_pkg::DelayW-1:0]    release_delay,
   output logic [mbd_pkg::CodeW-1:0]     code_next,
   output logic                          event_set
);
   import mbd_pkg::*;

   btn_state_type     state_ff, state_in;
   logic [DelayW-1:0] count_ff, count_in;
   logic              armed_ff, armed_in;

   // Next state: tick counts down and samples on expiry, edge starts a press check
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      armed_in  = armed_ff;
      event_set = 1'b0;
      if (step_en) begin
         if (cmd.tick && armed_ff) begin
            if (count_ff > DelayW'(1)) begin
               count_in = count_ff - DelayW'(1);
            end else if (!cmd.pin) begin
               // pin held low: confirm a pending press, keep re-sampling
               if (state_ff == BTN_UNSURE) begin
                  state_in  = BTN_DOWN;
                  event_set = 1'b1;
               end
               count_in = release_delay;
               armed_in = 1'b1;
            end else begin
               // pin back high: released
               count_in = '0;
               state_in = BTN_UP;
               armed_in = 1'b0;
            end
         end
         if (cmd.edge_hit && (state_ff == BTN_UP)) begin
            state_in = BTN_UNSURE;
            count_in = press_delay;
            armed_in = 1'b1;
         end
      end
   end

   assign code_next = state_code(state_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BTN_UP;
         count_ff <= '0;
         armed_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         armed_ff <= armed_in;
      end
   end

endmodule

FILE: hw/rtl/multi_button_debouncer_top.sv
// Top level of the multi-button debouncer: request register, button array, response register.
//
// Usage:
//  - req_chan carries one transaction per accepted valid/ready handshake: action 0 is a
//    tick with all pin levels, action 1 a falling edge on button_index, action 2 a read.
//    Action code 3 changes nothing but still returns a response.
//  - Every request yields exactly one response on rsp_chan: the status word (OR of each
//    button's state code shifted by its index, low 5 bits), read_ok (a read consumed a
//    pending press event) and event_pending (event flag after the request).
//  - Path: a request is loaded into the request register and, once rsp_chan is not
//    stalled, passes through the button update logic into the response register, which
//    drives response valid.
//  - Throughput is one transaction per cycle while rsp_chan does not stall; all button
//    timers update in parallel in a single logic stage; only the response register limits it.
//  - When rsp_chan stalls, the response register holds, the request register fills and
//    req_chan.ready drops; nothing is lost. Ready returns the cycle the response is taken.
//  - csr_we writes press (index 0) or release (index 1) delay in ticks; write only while
//    no transaction is in flight. A delay of zero acts as one tick.
//  - Synchronous reset: all buttons up, timers stopped, event flag clear, delays back to
//    20 and 100 ticks, both pipeline registers empty.
module multi_button_debouncer_top #(
   parameter int BUTTONS = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   mbd_req_if.sink                      req_chan,
   mbd_rsp_if.source                    rsp_chan,
   input  logic                         csr_we,
   input  logic [mbd_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [mbd_pkg::DelayW-1:0]   csr_wdata
);
   import mbd_pkg::*;

   localparam int PadS = (BUTTONS > StatusW) ? BUTTONS : StatusW;
   localparam int PadP = (BUTTONS > PinW) ? BUTTONS : PinW;

   // Configuration registers
   logic [DelayW-1:0] press_delay_ff;
   logic [DelayW-1:0] release_delay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         press_delay_ff   <= PressDelayRst;
         release_delay_ff <= ReleaseDelayRst;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PRESS_DELAY:   press_delay_ff   <= csr_wdata;
            CSR_RELEASE_DELAY: release_delay_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request register
   logic            req_vld_ff;
   action_type      req_action_ff;
   logic [IdxW-1:0] req_idx_ff;
   logic [PinW-1:0] req_pins_ff;
   logic            rsp_vld_ff;
   logic            step_en;
   logic            req_take;

   assign step_en        = req_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !req_vld_ff || step_en;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (req_take) begin
         req_vld_ff <= 1'b1;
      end else if (step_en) begin
         req_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_action_ff <= action_type'(req_chan.action);
         req_idx_ff    <= req_chan.button_index;
         req_pins_ff   <= req_chan.pin_levels;
      end
   end

   // Action decode
   logic is_tick, is_edge, is_read;

   always_comb begin
      is_tick = 1'b0;
      is_edge = 1'b0;
      is_read = 1'b0;
      unique case (req_action_ff)
         ACT_TICK: is_tick = 1'b1;
         ACT_EDGE: is_edge = 1'b1;
         ACT_READ: is_read = 1'b1;
         default: ;
      endcase
   end

   // Button array; pins above the pin field read low
   logic [PadP-1:0]  pins_pad;
   logic [CodeW-1:0] code_next [PadS];
   logic [BUTTONS-1:0] event_set;

   assign pins_pad = PadP'(req_pins_ff);

   for (genvar gi = 0; gi < PadS; gi++) begin : g_btn
      if (gi < BUTTONS) begin : g_live
         btn_cmd_type cmd;
         assign cmd.tick     = is_tick;
         assign cmd.edge_hit = is_edge && ({{(4-IdxW){1'b0}}, req_idx_ff} == 4'(gi));
         assign cmd.pin      = pins_pad[gi];

         mbd_button u_button (
            .clock         (clock),
            .reset         (reset),
            .step_en       (step_en),
            .cmd           (cmd),
            .press_delay   (press_delay_ff),
            .release_delay (release_delay_ff),
            .code_next     (code_next[gi]),
            .event_set     (event_set[gi])
         );
      end else begin : g_pad
         assign code_next[gi] = CodeUp;
      end
   end

   // Status word: bit j takes code j bit 0 and code j-1 bit 1
   logic [StatusW-1:0] status_next;

   always_comb begin
      status_next[0] = code_next[0][0];
      for (int j = 1; j < StatusW; j++) begin
         status_next[j] = code_next[j][0] | code_next[j-1][1];
      end
   end

   // Event flag
   logic event_flag_ff, event_flag_in;
   logic read_ok;

   always_comb begin
      event_flag_in = event_flag_ff;
      read_ok       = 1'b0;
      if (step_en) begin
         if (is_tick) begin
            event_flag_in = event_flag_ff | (|event_set);
         end else if (is_read) begin
            read_ok       = event_flag_ff;
            event_flag_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         event_flag_ff <= 1'b0;
      end else begin
         event_flag_ff <= event_flag_in;
      end
   end

   // Response register
   logic [StatusW-1:0] rsp_status_ff;
   logic               rsp_ok_ff;
   logic               rsp_pending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (step_en) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_status_ff  <= status_next;
         rsp_ok_ff      <= read_ok;
         rsp_pending_ff <= event_flag_in;
      end
   end

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.status_word   = rsp_status_ff;
   assign rsp_chan.read_ok       = rsp_ok_ff;
   assign rsp_chan.event_pending = rsp_pending_ff;

   // Checks
   a_ok_clears_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ok_ff) |-> !rsp_pending_ff)
      else $error("read_ok response still shows a pending event");

   a_pending_tracks_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_pending_ff == event_flag_ff))
      else $error("event_pending disagrees with the event flag");

   a_read_consumes: assert property (@(posedge clock) disable iff (reset)
      (step_en && is_read && event_flag_ff) |=> (rsp_ok_ff && !event_flag_ff))
      else $error("read of a pending event did not report and clear it");

endmodule
